FILE: rtl/c3ce_pkg.sv
// Shared constants, types and helpers of the 3x3 clamped-edge convolution block.
package c3ce_pkg;

    localparam int MAX_ORDER_DEF   = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int WEIGHT_W        = 16;
    localparam int KERNEL_W        = 3 * WEIGHT_W;
    localparam int ORDER_FIELD_W   = 7;
    localparam int CFG_IDX_W       = 8;
    localparam int ORDER_RESET     = 4;
    localparam int TAPS            = 9;

    localparam logic [KERNEL_W-1:0] KERNEL_TOP_RESET    = 48'h0000_0000_0000;
    localparam logic [KERNEL_W-1:0] KERNEL_CENTRE_RESET = 48'h0000_0100_0000;
    localparam logic [KERNEL_W-1:0] KERNEL_BELOW_RESET  = 48'h0000_0000_0000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ORDER         = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TOP    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_CENTRE = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BELOW  = 8'd3;

    // Where a sample sits relative to the matrix edges.
    typedef struct packed {
        logic r_ge1;
        logic r_ge2;
        logic r_last;
        logic c_ge1;
        logic c_ge2;
        logic c_last;
    } pos_flags_t;

    // Flags that travel with each result.
    typedef struct packed {
        logic run_last;
        logic frame_last;
    } res_tag_t;

    function automatic int idx_width(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    function automatic int value_width(input int sample_bits);
        return sample_bits + WEIGHT_W + 3;
    endfunction

endpackage

FILE: rtl/c3ce_if.sv
// Channel interfaces of the convolution block: samples in, results out, configuration.
interface c3ce_in_if #(
    parameter int SAMPLE_BITS = c3ce_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface c3ce_out_if #(
    parameter int MAX_ORDER   = c3ce_pkg::MAX_ORDER_DEF,
    parameter int SAMPLE_BITS = c3ce_pkg::SAMPLE_BITS_DEF
);
    import c3ce_pkg::*;

    localparam int IDX_W = idx_width(MAX_ORDER);
    localparam int VAL_W = value_width(SAMPLE_BITS);

    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic signed [VAL_W-1:0] out_value;
    logic                    run_last;
    logic                    frame_last;

    modport source (output valid, output out_row, output out_col, output out_value,
                    output run_last, output frame_last, input ready);
    modport sink   (input valid, input out_row, input out_col, input out_value,
                    input run_last, input frame_last, output ready);
endinterface

interface c3ce_cfg_if;
    import c3ce_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [KERNEL_W-1:0]  data;

    modport source (output valid, output reg_index, output data, input ready);
    modport sink   (input valid, input reg_index, input data, output ready);
endinterface

FILE: rtl/c3ce_ram.sv
// Single-port line memory with a registered, read-before-write data output.
module c3ce_ram #(
    parameter int DEPTH  = c3ce_pkg::MAX_ORDER_DEF,
    parameter int WIDTH  = c3ce_pkg::SAMPLE_BITS_DEF,
    parameter int ADDR_W = c3ce_pkg::idx_width(c3ce_pkg::MAX_ORDER_DEF)
) (
    input  logic              clk,
    input  logic              en,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata_reg <= mem[addr];
            if (we)
            begin
                mem[addr] <= wdata;
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/c3ce_line.sv
// Input stage: position counters and the two line memories holding the previous rows.
module c3ce_line #(
    parameter int MAX_ORDER   = c3ce_pkg::MAX_ORDER_DEF,
    parameter int SAMPLE_BITS = c3ce_pkg::SAMPLE_BITS_DEF,
    parameter int IDX_W       = c3ce_pkg::idx_width(c3ce_pkg::MAX_ORDER_DEF),
    parameter int ORD_W       = $clog2(c3ce_pkg::MAX_ORDER_DEF + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    c3ce_in_if.sink                       pixels,
    input  logic [ORD_W-1:0]              order,
    input  logic                          restart,
    input  logic                          take,
    output logic                          valid,
    output logic signed [SAMPLE_BITS-1:0] sample,
    output logic signed [SAMPLE_BITS-1:0] above1,
    output logic signed [SAMPLE_BITS-1:0] above2,
    output logic [IDX_W-1:0]              row,
    output logic [IDX_W-1:0]              col,
    output c3ce_pkg::pos_flags_t          flags
);

    import c3ce_pkg::*;

    logic                          accept;
    logic [IDX_W-1:0]              row_count_reg;
    logic [IDX_W-1:0]              col_count_reg;
    logic                          valid_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic [IDX_W-1:0]              row_reg;
    logic [IDX_W-1:0]              col_reg;
    pos_flags_t                    flags_reg;
    pos_flags_t                    flags_next;
    logic [ORD_W-1:0]              last_idx;
    logic [SAMPLE_BITS-1:0]        rd_even;
    logic [SAMPLE_BITS-1:0]        rd_odd;

    assign accept       = pixels.valid && pixels.ready;
    assign pixels.ready = !valid_reg || take;
    assign last_idx     = order - 1'b1;

    always_comb
    begin
        flags_next.r_ge1  = (row_count_reg != '0);
        flags_next.r_ge2  = (int'(row_count_reg) >= 2);
        flags_next.r_last = (ORD_W'(row_count_reg) == last_idx);
        flags_next.c_ge1  = (col_count_reg != '0);
        flags_next.c_ge2  = (int'(col_count_reg) >= 2);
        flags_next.c_last = (ORD_W'(col_count_reg) == last_idx);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= '0;
            col_count_reg <= '0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            if (restart)
            begin
                row_count_reg <= '0;
                col_count_reg <= '0;
            end
            else if (accept)
            begin
                if (flags_next.c_last)
                begin
                    col_count_reg <= '0;
                    row_count_reg <= flags_next.r_last ? '0 : row_count_reg + 1'b1;
                end
                else
                begin
                    col_count_reg <= col_count_reg + 1'b1;
                end
            end

            if (accept)
            begin
                valid_reg <= 1'b1;
            end
            else if (take)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= pixels.sample;
            row_reg    <= row_count_reg;
            col_reg    <= col_count_reg;
            flags_reg  <= flags_next;
        end
    end

    // Even rows live in one bank and odd rows in the other, so the bank of the
    // current row still holds the row two above until it is overwritten.
    c3ce_ram #(
        .DEPTH  (MAX_ORDER),
        .WIDTH  (SAMPLE_BITS),
        .ADDR_W (IDX_W)
    ) u_bank_even (
        .clk   (clk),
        .en    (accept),
        .we    (!row_count_reg[0]),
        .addr  (col_count_reg),
        .wdata (pixels.sample),
        .rdata (rd_even)
    );

    c3ce_ram #(
        .DEPTH  (MAX_ORDER),
        .WIDTH  (SAMPLE_BITS),
        .ADDR_W (IDX_W)
    ) u_bank_odd (
        .clk   (clk),
        .en    (accept),
        .we    (row_count_reg[0]),
        .addr  (col_count_reg),
        .wdata (pixels.sample),
        .rdata (rd_odd)
    );

    assign valid  = valid_reg;
    assign sample = sample_reg;
    assign above2 = row_reg[0] ? $signed(rd_odd) : $signed(rd_even);
    assign above1 = row_reg[0] ? $signed(rd_even) : $signed(rd_odd);
    assign row    = row_reg;
    assign col    = col_reg;
    assign flags  = flags_reg;

endmodule

FILE: rtl/c3ce_win.sv
// 3x3 window and result sequencer: picks the clamped operands for each result position.
module c3ce_win #(
    parameter int SAMPLE_BITS = c3ce_pkg::SAMPLE_BITS_DEF,
    parameter int IDX_W       = c3ce_pkg::idx_width(c3ce_pkg::MAX_ORDER_DEF)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic signed [SAMPLE_BITS-1:0] above1,
    input  logic signed [SAMPLE_BITS-1:0] above2,
    input  logic [IDX_W-1:0]              row,
    input  logic [IDX_W-1:0]              col,
    input  c3ce_pkg::pos_flags_t          flags,
    output logic                          take,
    output logic                          op_valid,
    input  logic                          op_ready,
    output logic signed [SAMPLE_BITS-1:0] ops [c3ce_pkg::TAPS],
    output logic [IDX_W-1:0]              pr,
    output logic [IDX_W-1:0]              pc,
    output c3ce_pkg::res_tag_t            tag
);

    import c3ce_pkg::*;

    localparam logic [1:0] POS_OLD = 2'd0;
    localparam logic [1:0] POS_MID = 2'd1;
    localparam logic [1:0] POS_NEW = 2'd2;

    logic signed [SAMPLE_BITS-1:0] win_reg [TAPS];
    logic                          g_valid_reg;
    logic                          a_idx_reg;
    logic                          b_idx_reg;
    pos_flags_t                    gflags_reg;
    logic [IDX_W-1:0]              grow_reg;
    logic [IDX_W-1:0]              gcol_reg;

    logic                          two_rows;
    logic                          two_cols;
    logic                          last;
    logic                          issue;
    logic                          done;
    logic                          has_results;
    logic                          pr_is_cur;
    logic                          pc_is_cur;
    logic [1:0]                    rsel [3];
    logic [1:0]                    csel [3];
    logic signed [SAMPLE_BITS-1:0] rowv [3][3];

    function automatic logic signed [SAMPLE_BITS-1:0] pick3(
        input logic signed [SAMPLE_BITS-1:0] v0,
        input logic signed [SAMPLE_BITS-1:0] v1,
        input logic signed [SAMPLE_BITS-1:0] v2,
        input logic [1:0]                    sel
    );
        logic signed [SAMPLE_BITS-1:0] res;
        case (sel)
            POS_OLD: res = v0;
            POS_MID: res = v1;
            default: res = v2;
        endcase
        return res;
    endfunction

    assign two_rows    = gflags_reg.r_ge1 && gflags_reg.r_last;
    assign two_cols    = gflags_reg.c_ge1 && gflags_reg.c_last;
    assign last        = (a_idx_reg == two_rows) && (b_idx_reg == two_cols);
    assign issue       = g_valid_reg && op_ready;
    assign done        = !g_valid_reg || (op_ready && last);
    assign take        = in_valid && done;
    assign has_results = (flags.r_ge1 || flags.r_last) && (flags.c_ge1 || flags.c_last);

    // The position is on the newest row when it is the second of two rows or
    // when there is no row above to finish.
    assign pr_is_cur = a_idx_reg || !gflags_reg.r_ge1;
    assign pc_is_cur = b_idx_reg || !gflags_reg.c_ge1;

    always_comb
    begin
        rsel[0] = pr_is_cur ? (gflags_reg.r_ge1 ? POS_MID : POS_NEW)
                            : (gflags_reg.r_ge2 ? POS_OLD : POS_MID);
        rsel[1] = pr_is_cur ? POS_NEW : POS_MID;
        rsel[2] = POS_NEW;
        csel[0] = pc_is_cur ? (gflags_reg.c_ge1 ? POS_MID : POS_NEW)
                            : (gflags_reg.c_ge2 ? POS_OLD : POS_MID);
        csel[1] = pc_is_cur ? POS_NEW : POS_MID;
        csel[2] = POS_NEW;
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                rowv[i][k] = pick3(win_reg[k], win_reg[3 + k], win_reg[6 + k], rsel[i]);
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                ops[3 * i + j] = pick3(rowv[i][0], rowv[i][1], rowv[i][2], csel[j]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_valid_reg <= 1'b0;
            a_idx_reg   <= 1'b0;
            b_idx_reg   <= 1'b0;
        end
        else if (take)
        begin
            g_valid_reg <= has_results;
            a_idx_reg   <= 1'b0;
            b_idx_reg   <= 1'b0;
        end
        else if (issue)
        begin
            if (last)
            begin
                g_valid_reg <= 1'b0;
            end
            else if (b_idx_reg != two_cols)
            begin
                b_idx_reg <= 1'b1;
            end
            else
            begin
                b_idx_reg <= 1'b0;
                a_idx_reg <= 1'b1;
            end
        end
    end

    // The window moves one column each time a sample enters it.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_reg[3 * k]     <= win_reg[3 * k + 1];
                win_reg[3 * k + 1] <= win_reg[3 * k + 2];
            end
            win_reg[2] <= above2;
            win_reg[5] <= above1;
            win_reg[8] <= sample;
            gflags_reg <= flags;
            grow_reg   <= row;
            gcol_reg   <= col;
        end
    end

    assign op_valid       = g_valid_reg;
    assign pr             = pr_is_cur ? grow_reg : grow_reg - 1'b1;
    assign pc             = pc_is_cur ? gcol_reg : gcol_reg - 1'b1;
    assign tag.run_last   = last;
    assign tag.frame_last = pr_is_cur && gflags_reg.r_last && pc_is_cur && gflags_reg.c_last;

endmodule

FILE: rtl/c3ce_mac.sv
// Multiply-accumulate pipeline: operand register, nine products, partial sums, result register.
module c3ce_mac #(
    parameter int SAMPLE_BITS = c3ce_pkg::SAMPLE_BITS_DEF,
    parameter int IDX_W       = c3ce_pkg::idx_width(c3ce_pkg::MAX_ORDER_DEF),
    parameter int VAL_W       = c3ce_pkg::value_width(c3ce_pkg::SAMPLE_BITS_DEF)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] ops [c3ce_pkg::TAPS],
    input  logic [IDX_W-1:0]              pr,
    input  logic [IDX_W-1:0]              pc,
    input  c3ce_pkg::res_tag_t            tag,
    input  logic [c3ce_pkg::KERNEL_W-1:0] kernel_top,
    input  logic [c3ce_pkg::KERNEL_W-1:0] kernel_centre,
    input  logic [c3ce_pkg::KERNEL_W-1:0] kernel_below,
    c3ce_out_if.source                    results
);

    import c3ce_pkg::*;

    localparam int PROD_W = SAMPLE_BITS + WEIGHT_W;

    logic signed [WEIGHT_W-1:0]    w [TAPS];
    logic [KERNEL_W-1:0]           kern [3];

    logic                          s1_valid_reg;
    logic signed [SAMPLE_BITS-1:0] op_reg [TAPS];
    logic [IDX_W-1:0]              row1_reg;
    logic [IDX_W-1:0]              col1_reg;
    res_tag_t                      tag1_reg;

    logic                          s2_valid_reg;
    logic signed [PROD_W-1:0]      prod_next [TAPS];
    logic signed [PROD_W-1:0]      prod_reg [TAPS];
    logic [IDX_W-1:0]              row2_reg;
    logic [IDX_W-1:0]              col2_reg;
    res_tag_t                      tag2_reg;

    logic                          s3_valid_reg;
    logic signed [VAL_W-1:0]       part_next [3];
    logic signed [VAL_W-1:0]       part_reg [3];
    logic [IDX_W-1:0]              row3_reg;
    logic [IDX_W-1:0]              col3_reg;
    res_tag_t                      tag3_reg;

    logic                          s4_valid_reg;
    logic signed [VAL_W-1:0]       sum_next;
    logic signed [VAL_W-1:0]       sum_reg;
    logic [IDX_W-1:0]              row4_reg;
    logic [IDX_W-1:0]              col4_reg;
    res_tag_t                      tag4_reg;

    logic                          s1_ready;
    logic                          s2_ready;
    logic                          s3_ready;
    logic                          s4_ready;

    assign s4_ready = !s4_valid_reg || results.ready;
    assign s3_ready = !s3_valid_reg || s4_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_comb
    begin
        kern[0] = kernel_top;
        kern[1] = kernel_centre;
        kern[2] = kernel_below;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                w[3 * i + j] = $signed(kern[i][WEIGHT_W * j +: WEIGHT_W]);
            end
        end
        for (int k = 0; k < TAPS; k++)
        begin
            prod_next[k] = op_reg[k] * w[k];
        end
        for (int i = 0; i < 3; i++)
        begin
            part_next[i] = VAL_W'(prod_reg[3 * i]) + VAL_W'(prod_reg[3 * i + 1])
                         + VAL_W'(prod_reg[3 * i + 2]);
        end
        sum_next = part_reg[0] + part_reg[1] + part_reg[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_ready)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            op_reg   <= ops;
            row1_reg <= pr;
            col1_reg <= pc;
            tag1_reg <= tag;
        end
        if (s2_ready && s1_valid_reg)
        begin
            prod_reg <= prod_next;
            row2_reg <= row1_reg;
            col2_reg <= col1_reg;
            tag2_reg <= tag1_reg;
        end
        if (s3_ready && s2_valid_reg)
        begin
            part_reg <= part_next;
            row3_reg <= row2_reg;
            col3_reg <= col2_reg;
            tag3_reg <= tag2_reg;
        end
        if (s4_ready && s3_valid_reg)
        begin
            sum_reg  <= sum_next;
            row4_reg <= row3_reg;
            col4_reg <= col3_reg;
            tag4_reg <= tag3_reg;
        end
    end

    assign results.valid      = s4_valid_reg;
    assign results.out_row    = row4_reg;
    assign results.out_col    = col4_reg;
    assign results.out_value  = sum_reg;
    assign results.run_last   = tag4_reg.run_last;
    assign results.frame_last = tag4_reg.frame_last;

endmodule

FILE: rtl/conv3x3_clamp_edge.sv
// Top level of the streaming 3x3 convolution with replicated matrix border.
//
//   channel   dir   request carries
//   -------   ---   ------------------------------------------------------
//   pixels    in    sample, next matrix element in row-major order
//   results   out   out_row, out_col, out_value, run_last, frame_last
//   cfg       in    reg_index, data (order, kernel top, centre, below)
//
// A sample is taken every cycle while each sample causes at most one result and the
// results channel does not stall; one that causes more results holds the pixel
// channel until all are issued, since the window sequencer hands one result per
// cycle to the multipliers while they accept. A result passes these registers after
// its last sample: line memory read, window, operand register, products, partial
// sums, result register. The line memories need no reset and get no clearing pass.
// Configuration requests are always taken; a write to the order restarts the frame.
module conv3x3_clamp_edge #(
    parameter int MAX_ORDER   = c3ce_pkg::MAX_ORDER_DEF,
    parameter int SAMPLE_BITS = c3ce_pkg::SAMPLE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    c3ce_in_if.sink     pixels,
    c3ce_out_if.source  results,
    c3ce_cfg_if.sink    cfg
);

    import c3ce_pkg::*;

    localparam int IDX_W      = idx_width(MAX_ORDER);
    localparam int ORD_W      = $clog2(MAX_ORDER + 1);
    localparam int VAL_W      = value_width(SAMPLE_BITS);
    localparam int ORDER_INIT = (ORDER_RESET > MAX_ORDER) ? MAX_ORDER : ORDER_RESET;

    logic [ORD_W-1:0]              order_reg;
    logic [KERNEL_W-1:0]           kernel_top_reg;
    logic [KERNEL_W-1:0]           kernel_centre_reg;
    logic [KERNEL_W-1:0]           kernel_below_reg;
    logic [ORDER_FIELD_W-1:0]      order_raw;
    logic [ORD_W-1:0]              order_next;
    logic                          cfg_write;
    logic                          restart;

    logic                          line_valid;
    logic signed [SAMPLE_BITS-1:0] line_sample;
    logic signed [SAMPLE_BITS-1:0] line_above1;
    logic signed [SAMPLE_BITS-1:0] line_above2;
    logic [IDX_W-1:0]              line_row;
    logic [IDX_W-1:0]              line_col;
    pos_flags_t                    line_flags;
    logic                          take;

    logic                          op_valid;
    logic                          op_ready;
    logic signed [SAMPLE_BITS-1:0] ops [TAPS];
    logic [IDX_W-1:0]              pr;
    logic [IDX_W-1:0]              pc;
    res_tag_t                      tag;

    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;
    assign restart   = cfg_write && (cfg.reg_index == REG_ORDER);
    assign order_raw = cfg.data[ORDER_FIELD_W-1:0];

    // An order of zero means one; anything above the line length saturates.
    always_comb
    begin
        if (order_raw == '0)
        begin
            order_next = ORD_W'(1);
        end
        else if (int'(order_raw) > MAX_ORDER)
        begin
            order_next = ORD_W'(MAX_ORDER);
        end
        else
        begin
            order_next = ORD_W'(order_raw);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg         <= ORD_W'(ORDER_INIT);
            kernel_top_reg    <= KERNEL_TOP_RESET;
            kernel_centre_reg <= KERNEL_CENTRE_RESET;
            kernel_below_reg  <= KERNEL_BELOW_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg.reg_index)
                REG_ORDER:         order_reg         <= order_next;
                REG_KERNEL_TOP:    kernel_top_reg    <= cfg.data;
                REG_KERNEL_CENTRE: kernel_centre_reg <= cfg.data;
                REG_KERNEL_BELOW:  kernel_below_reg  <= cfg.data;
                default:           ;
            endcase
        end
    end

    c3ce_line #(
        .MAX_ORDER   (MAX_ORDER),
        .SAMPLE_BITS (SAMPLE_BITS),
        .IDX_W       (IDX_W),
        .ORD_W       (ORD_W)
    ) u_line (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixels  (pixels),
        .order   (order_reg),
        .restart (restart),
        .take    (take),
        .valid   (line_valid),
        .sample  (line_sample),
        .above1  (line_above1),
        .above2  (line_above2),
        .row     (line_row),
        .col     (line_col),
        .flags   (line_flags)
    );

    c3ce_win #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .IDX_W       (IDX_W)
    ) u_win (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (line_valid),
        .sample   (line_sample),
        .above1   (line_above1),
        .above2   (line_above2),
        .row      (line_row),
        .col      (line_col),
        .flags    (line_flags),
        .take     (take),
        .op_valid (op_valid),
        .op_ready (op_ready),
        .ops      (ops),
        .pr       (pr),
        .pc       (pc),
        .tag      (tag)
    );

    c3ce_mac #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .IDX_W       (IDX_W),
        .VAL_W       (VAL_W)
    ) u_mac (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (op_valid),
        .in_ready      (op_ready),
        .ops           (ops),
        .pr            (pr),
        .pc            (pc),
        .tag           (tag),
        .kernel_top    (kernel_top_reg),
        .kernel_centre (kernel_centre_reg),
        .kernel_below  (kernel_below_reg),
        .results       (results)
    );

endmodule
